// ----- hdl/cdpc_pkg.sv -----
// Shared constants, types and address helpers for the clock digit pixel compositor.
package cdpc_pkg;

    // Glyph geometry
    localparam int GLYPH_W    = 5;
    localparam int GLYPH_H    = 9;
    localparam int NUM_GLYPHS = 10;
    localparam int NUM_CELLS  = 6;

    // Field widths
    localparam int PIX_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int TIME_W  = 7;

    // Store geometry
    localparam int STORE_DEPTH = NUM_GLYPHS * GLYPH_W * GLYPH_H;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Clock image geometry
    localparam int IMAGE_W    = 6 * GLYPH_W + 9;
    localparam int COLON_COL0 = 2 * GLYPH_W + 2;
    localparam int COLON_COL1 = 4 * GLYPH_W + 6;
    localparam int COLON_ROW0 = GLYPH_H / 3;
    localparam int COLON_ROW1 = (2 * GLYPH_H) / 3;
    localparam logic [PIX_W-1:0] COLON_VALUE = PIX_W'(15);

    // First column of each digit cell
    localparam int CELL_START [NUM_CELLS] = '{
        0, GLYPH_W + 1, 2 * GLYPH_W + 4, 3 * GLYPH_W + 5, 4 * GLYPH_W + 8, 5 * GLYPH_W + 9
    };

    // Item kinds
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } cmd_t;

    // Decode result handed from the decoder to the pipeline
    typedef struct packed {
        logic              we;
        logic              use_glyph;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  fixed_pix;
        logic              in_range;
    } dec_t;

    // Linear store address of one glyph pixel
    function automatic logic [ADDR_W-1:0] glyph_addr(
        input logic [DIGIT_W-1:0] dig,
        input logic [ROW_W-1:0]   r,
        input logic [COL_W-1:0]   c
    );
        int lin;
        lin = (int'(dig) * GLYPH_H + int'(r)) * GLYPH_W + int'(c);
        return ADDR_W'(lin);
    endfunction

endpackage

// ----- hdl/cdpc_glyph_ram.sv -----
// Single-port glyph store with registered read data.
module cdpc_glyph_ram (
    input  logic                         aclk,
    input  logic                         we,
    input  logic                         re,
    input  logic [cdpc_pkg::ADDR_W-1:0]  addr,
    input  logic [cdpc_pkg::PIX_W-1:0]   wdata,
    output logic [cdpc_pkg::PIX_W-1:0]   rdata
);

    logic [cdpc_pkg::PIX_W-1:0] mem [cdpc_pkg::STORE_DEPTH];
    logic [cdpc_pkg::PIX_W-1:0] rdata_reg;

    // Write one glyph pixel
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    // Read and hold until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cdpc_decode.sv -----
// Decodes one item into a store access and the fixed pixel value for it.
module cdpc_decode (
    input  logic                         cmd,
    input  logic [cdpc_pkg::DIGIT_W-1:0] digit,
    input  logic [cdpc_pkg::ROW_W-1:0]   row,
    input  logic [cdpc_pkg::COL_W-1:0]   col,
    input  logic [cdpc_pkg::TIME_W-1:0]  hours,
    input  logic [cdpc_pkg::TIME_W-1:0]  minutes,
    input  logic [cdpc_pkg::TIME_W-1:0]  seconds,
    output cdpc_pkg::dec_t               dec
);

    // Tens digit by reciprocal multiply: exact for every 7-bit input, 0 to 127
    function automatic logic [cdpc_pkg::DIGIT_W-1:0] tens_of(
        input logic [cdpc_pkg::TIME_W-1:0] v
    );
        logic [15:0] p;
        p = 16'(v) * 16'd205;
        return p[14:11];
    endfunction

    function automatic logic [cdpc_pkg::DIGIT_W-1:0] units_of(
        input logic [cdpc_pkg::TIME_W-1:0] v
    );
        logic [cdpc_pkg::TIME_W-1:0] t10;
        t10 = cdpc_pkg::TIME_W'(tens_of(v)) * cdpc_pkg::TIME_W'(10);
        return cdpc_pkg::DIGIT_W'(v - t10);
    endfunction

    logic [cdpc_pkg::DIGIT_W-1:0] digs [cdpc_pkg::NUM_CELLS];
    logic                         is_write;
    logic                         row_ok;
    logic                         wr_ok;
    logic                         rd_ok;
    logic                         hit;
    logic                         colon_col;
    logic                         colon_row;
    logic [cdpc_pkg::DIGIT_W-1:0] cell_dig;
    logic [cdpc_pkg::COL_W-1:0]   cell_col;
    logic [cdpc_pkg::DIGIT_W-1:0] sel_dig;
    logic [cdpc_pkg::COL_W-1:0]   sel_col;

    // Split the time values into six digits
    always_comb begin
        digs[0] = tens_of(hours);
        digs[1] = units_of(hours);
        digs[2] = tens_of(minutes);
        digs[3] = units_of(minutes);
        digs[4] = tens_of(seconds);
        digs[5] = units_of(seconds);
    end

    // Find the digit cell that holds the column
    always_comb begin
        hit      = 1'b0;
        cell_dig = '0;
        cell_col = '0;
        for (int k = 0; k < cdpc_pkg::NUM_CELLS; k++) begin
            if (int'(col) >= cdpc_pkg::CELL_START[k] &&
                int'(col) < cdpc_pkg::CELL_START[k] + cdpc_pkg::GLYPH_W) begin
                hit      = 1'b1;
                cell_dig = digs[k];
                cell_col = cdpc_pkg::COL_W'(int'(col) - cdpc_pkg::CELL_START[k]);
            end
        end
    end

    // Bounds, colon and store access
    always_comb begin
        is_write  = (cdpc_pkg::cmd_t'(cmd) == cdpc_pkg::CMD_WRITE);
        row_ok    = int'(row) < cdpc_pkg::GLYPH_H;
        wr_ok     = (int'(digit) < cdpc_pkg::NUM_GLYPHS) && row_ok &&
                    (int'(col) < cdpc_pkg::GLYPH_W);
        rd_ok     = row_ok && (int'(col) < cdpc_pkg::IMAGE_W);
        colon_col = (int'(col) == cdpc_pkg::COLON_COL0) ||
                    (int'(col) == cdpc_pkg::COLON_COL1);
        colon_row = (int'(row) == cdpc_pkg::COLON_ROW0) ||
                    (int'(row) == cdpc_pkg::COLON_ROW1);
        sel_dig   = is_write ? digit : cell_dig;
        sel_col   = is_write ? col : cell_col;

        dec.we        = is_write && wr_ok;
        dec.use_glyph = !is_write && rd_ok && hit &&
                        (int'(cell_dig) < cdpc_pkg::NUM_GLYPHS);
        dec.addr      = cdpc_pkg::glyph_addr(sel_dig, row, sel_col);
        dec.fixed_pix = (!is_write && rd_ok && colon_col && colon_row) ?
                        cdpc_pkg::COLON_VALUE : '0;
        dec.in_range  = is_write ? wr_ok : rd_ok;
    end

endmodule

// ----- hdl/clock_digit_pixel_compositor.sv -----
// Top level of the clock digit pixel compositor: handshake, pipeline and result register.
//
// Usage:
//   The s_ channel takes items. s_tuser is the kind: 0 writes one glyph pixel
//   (digit, row, col, pixel_value), 1 renders one pixel of the HH:MM:SS image
//   (row, col, hours, minutes, seconds). Every item gives exactly one result
//   on the m_ channel: m_tdata holds the pixel, m_tuser says whether the
//   coordinate lay inside the glyph (write) or the image (render).
//   Fill each glyph entry before rendering a pixel that uses it.
//   An accepted item passes the read stage, then the result register that drives m_tvalid.
//   Throughput is one item per cycle while the receiver does not stall, set by the
//   single glyph store port that serves one read or one write per item.
//   Reset (aresetn low, synchronous) empties the pipeline and drops m_tvalid;
//   the glyph store keeps its contents and needs no clearing pass.
//   When the receiver stalls, the result register holds its item, the read
//   stage fills behind it, and s_tready falls only once both are occupied.
module clock_digit_pixel_compositor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // digit[3:0], row[8:4], col[15:9], pixel_value[19:16], hours[26:20],
    // minutes[33:27], seconds[40:34], zero[47:41]
    input  logic [47:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel[3:0], zero[7:4]
    output logic [7:0]  m_tdata,
    // in_range[0]
    output logic        m_tuser
);

    cdpc_pkg::dec_t                dec;
    logic                          accept;
    logic                          a_adv;
    logic [cdpc_pkg::PIX_W-1:0]    rdata;

    logic                          a_valid_reg, a_valid_next;
    logic                          a_use_reg;
    logic [cdpc_pkg::PIX_W-1:0]    a_fix_reg;
    logic                          a_range_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [cdpc_pkg::PIX_W-1:0]    m_pix_reg;
    logic                          m_range_reg;

    // Decode the incoming item
    cdpc_decode u_decode (
        .cmd     (s_tuser),
        .digit   (s_tdata[3:0]),
        .row     (s_tdata[8:4]),
        .col     (s_tdata[15:9]),
        .hours   (s_tdata[26:20]),
        .minutes (s_tdata[33:27]),
        .seconds (s_tdata[40:34]),
        .dec     (dec)
    );

    // Handshake: read stage advances when the result register is free or taken
    assign a_adv    = !m_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || a_adv;
    assign accept   = s_tvalid && s_tready;

    // Glyph store access on accept
    cdpc_glyph_ram u_glyph_ram (
        .aclk  (aclk),
        .we    (accept && dec.we),
        .re    (accept && dec.use_glyph),
        .addr  (dec.addr),
        .wdata (s_tdata[19:16]),
        .rdata (rdata)
    );

    // Next valid flags
    always_comb begin
        if (accept) begin
            a_valid_next = 1'b1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end else begin
            a_valid_next = a_valid_reg;
        end
        m_valid_next = a_adv ? a_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture read stage control alongside the store read
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_use_reg   <= dec.use_glyph;
            a_fix_reg   <= dec.fixed_pix;
            a_range_reg <= dec.in_range;
        end
    end

    // Load the result register
    always_ff @(posedge aclk) begin
        if (a_adv && a_valid_reg) begin
            m_pix_reg   <= a_use_reg ? rdata : a_fix_reg;
            m_range_reg <= a_range_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_pix_reg};
    assign m_tuser  = m_range_reg;

endmodule

// ----- hdl/cdpc_checker.sv -----
// Port-level checks for the clock digit pixel compositor, bound to the top level.
module cdpc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser
);

    // Reset empties the result side
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Out-of-range coordinates and writes outside bounds show pixel zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[3:0] == 4'h0)
        else $error("nonzero pixel with in_range clear");

    // A result appearing on an empty output comes from an item accepted through the read stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching item");

endmodule

bind clock_digit_pixel_compositor cdpc_checker u_cdpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- bench/clock_digit_pixel_compositor_tb.sv -----
// Self-checking testbench for the clock digit pixel compositor: glyph writes and clock renders.
module clock_digit_pixel_compositor_tb;

    localparam int TOTAL_ITEMS = 1650;
    localparam int CALM_TAIL   = 250;
    localparam int STORE_SIZE  = cdpc_pkg::NUM_GLYPHS * cdpc_pkg::GLYPH_H * cdpc_pkg::GLYPH_W;
    localparam logic [cdpc_pkg::PIX_W-1:0] COLON_LEVEL = 4'hF;

    typedef struct {
        cdpc_pkg::cmd_t                kind;
        logic [cdpc_pkg::DIGIT_W-1:0]  digit;
        logic [cdpc_pkg::ROW_W-1:0]    row;
        logic [cdpc_pkg::COL_W-1:0]    col;
        logic [cdpc_pkg::PIX_W-1:0]    level;
        logic [cdpc_pkg::TIME_W-1:0]   hh;
        logic [cdpc_pkg::TIME_W-1:0]   mm;
        logic [cdpc_pkg::TIME_W-1:0]   ss;
        bit                            hold_for_drain;
    } clock_item_t;

    typedef struct packed {
        logic [cdpc_pkg::PIX_W-1:0] pixel;
        logic                       in_range;
    } pixel_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tuser;

    clock_digit_pixel_compositor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    clock_item_t                pending_items[$];
    pixel_result_t              expected_pixels[$];
    clock_item_t                cur_item;
    logic [cdpc_pkg::PIX_W-1:0] glyph_img
        [cdpc_pkg::NUM_GLYPHS][cdpc_pkg::GLYPH_H][cdpc_pkg::GLYPH_W];
    bit                         glyph_filled
        [cdpc_pkg::NUM_GLYPHS][cdpc_pkg::GLYPH_H][cdpc_pkg::GLYPH_W];
    int                         mismatches = 0;
    bit                         taken      = 1'b0;
    int                         send_gap   = 0;
    int                         stall_left = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Idle only outside the tail and outside periodic quiet stretches
    function automatic bit may_idle();
        return pending_items.size() > CALM_TAIL && (pending_items.size() % 300) >= 100;
    endfunction

    // Find which glyph pixel a render reads; 0 when it reads none
    function automatic bit glyph_source(clock_item_t it, output int g, output int gc);
        int starts [cdpc_pkg::NUM_CELLS];
        int digs   [cdpc_pkg::NUM_CELLS];
        starts = '{0, cdpc_pkg::GLYPH_W + 1, 2 * cdpc_pkg::GLYPH_W + 4,
                   3 * cdpc_pkg::GLYPH_W + 5, 4 * cdpc_pkg::GLYPH_W + 8,
                   5 * cdpc_pkg::GLYPH_W + 9};
        digs   = '{int'(it.hh) / 10, int'(it.hh) % 10, int'(it.mm) / 10,
                   int'(it.mm) % 10, int'(it.ss) / 10, int'(it.ss) % 10};
        g  = 0;
        gc = 0;
        if (it.kind != cdpc_pkg::CMD_RENDER || it.row >= cdpc_pkg::GLYPH_H)
            return 1'b0;
        for (int k = 0; k < cdpc_pkg::NUM_CELLS; k++) begin
            if (int'(it.col) >= starts[k] &&
                int'(it.col) < starts[k] + cdpc_pkg::GLYPH_W) begin
                g  = digs[k];
                gc = int'(it.col) - starts[k];
                return g < cdpc_pkg::NUM_GLYPHS;
            end
        end
        return 1'b0;
    endfunction

    // Compute the pixel an item yields and apply writes to the glyph copy
    function automatic pixel_result_t predict_pixel(clock_item_t it);
        pixel_result_t res;
        int            g;
        int            gc;
        res = '{pixel: '0, in_range: 1'b0};
        if (it.kind == cdpc_pkg::CMD_WRITE) begin
            if (it.digit < cdpc_pkg::NUM_GLYPHS && it.row < cdpc_pkg::GLYPH_H &&
                it.col < cdpc_pkg::GLYPH_W) begin
                glyph_img[it.digit][it.row][it.col] = it.level;
                res.in_range = 1'b1;
            end
        end else if (it.row < cdpc_pkg::GLYPH_H && it.col < cdpc_pkg::IMAGE_W) begin
            res.in_range = 1'b1;
            if (glyph_source(it, g, gc))
                res.pixel = glyph_img[g][it.row][gc];
            else if ((it.col == 2 * cdpc_pkg::GLYPH_W + 2 ||
                      it.col == 4 * cdpc_pkg::GLYPH_W + 6) &&
                     (it.row == cdpc_pkg::GLYPH_H / 3 ||
                      it.row == (2 * cdpc_pkg::GLYPH_H) / 3))
                res.pixel = COLON_LEVEL;
        end
        return res;
    endfunction

    function automatic clock_item_t make_write(int d, int r, int c, int v);
        clock_item_t it;
        it.kind  = cdpc_pkg::CMD_WRITE;
        it.digit = cdpc_pkg::DIGIT_W'(d);
        it.row   = cdpc_pkg::ROW_W'(r);
        it.col   = cdpc_pkg::COL_W'(c);
        it.level = cdpc_pkg::PIX_W'(v);
        it.hh    = cdpc_pkg::TIME_W'($urandom_range(0, 127));
        it.mm    = cdpc_pkg::TIME_W'($urandom_range(0, 127));
        it.ss    = cdpc_pkg::TIME_W'($urandom_range(0, 127));
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    function automatic clock_item_t make_render(int r, int c, int h, int m, int s);
        clock_item_t it;
        it.kind  = cdpc_pkg::CMD_RENDER;
        it.digit = cdpc_pkg::DIGIT_W'($urandom_range(0, 15));
        it.row   = cdpc_pkg::ROW_W'(r);
        it.col   = cdpc_pkg::COL_W'(c);
        it.level = cdpc_pkg::PIX_W'($urandom_range(0, 15));
        it.hh    = cdpc_pkg::TIME_W'(h);
        it.mm    = cdpc_pkg::TIME_W'(m);
        it.ss    = cdpc_pkg::TIME_W'(s);
        it.hold_for_drain = 1'b0;
        return it;
    endfunction

    function automatic int random_time();
        return ($urandom_range(0, 6) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 99);
    endfunction

    // Draw renders, mostly in range, and skip any that read an unfilled glyph pixel
    function automatic clock_item_t random_render();
        clock_item_t it;
        int          g;
        int          gc;
        do begin
            it = make_render(
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                            : $urandom_range(0, cdpc_pkg::GLYPH_H - 1),
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                            : $urandom_range(0, cdpc_pkg::IMAGE_W - 1),
                random_time(), random_time(), random_time());
        end while (glyph_source(it, g, gc) && !glyph_filled[g][it.row][gc]);
        return it;
    endfunction

    function automatic clock_item_t random_write();
        if ($urandom_range(0, 4) == 0)
            return make_write($urandom_range(0, 15), $urandom_range(0, 31),
                              $urandom_range(0, 127), $urandom_range(0, 15));
        return make_write($urandom_range(0, cdpc_pkg::NUM_GLYPHS - 1),
                          $urandom_range(0, cdpc_pkg::GLYPH_H - 1),
                          $urandom_range(0, cdpc_pkg::GLYPH_W - 1),
                          $urandom_range(0, 15));
    endfunction

    // Queue one item and track which glyph pixels it fills
    task automatic queue_item(clock_item_t it);
        if (it.kind == cdpc_pkg::CMD_WRITE && it.digit < cdpc_pkg::NUM_GLYPHS &&
            it.row < cdpc_pkg::GLYPH_H && it.col < cdpc_pkg::GLYPH_W)
            glyph_filled[it.digit][it.row][it.col] = 1'b1;
        pending_items.push_back(it);
    endtask

    // Stimulus, reset and end of run
    initial begin
        clock_item_t it;
        int          order[$];
        int          pick;
        int          tmp;
        // Glyph corners, then writes outside the glyph bounds
        queue_item(make_write(0, 0, 0, 15));
        queue_item(make_write(cdpc_pkg::NUM_GLYPHS - 1, cdpc_pkg::GLYPH_H - 1,
                              cdpc_pkg::GLYPH_W - 1, 0));
        queue_item(make_write(cdpc_pkg::NUM_GLYPHS - 1, 0, 0, 10));
        queue_item(make_write(0, cdpc_pkg::GLYPH_H - 1, cdpc_pkg::GLYPH_W - 1, 5));
        queue_item(make_write(cdpc_pkg::NUM_GLYPHS, 0, 0, 7));
        queue_item(make_write(15, 31, 127, 15));
        queue_item(make_write(0, cdpc_pkg::GLYPH_H, 0, 3));
        queue_item(make_write(0, 0, cdpc_pkg::GLYPH_W, 3));
        // Renders of filled glyph pixels, gaps, colons, oversized times, out of range
        queue_item(make_render(0, 0, 0, 0, 0));
        queue_item(make_render(cdpc_pkg::GLYPH_H - 1, cdpc_pkg::IMAGE_W - 1, 0, 0, 59));
        queue_item(make_render(0, 2 * cdpc_pkg::GLYPH_W + 4, 0, 99, 0));
        queue_item(make_render(cdpc_pkg::GLYPH_H - 1, cdpc_pkg::GLYPH_W - 1, 0, 0, 0));
        queue_item(make_render(0, cdpc_pkg::GLYPH_W, 0, 0, 0));
        queue_item(make_render(cdpc_pkg::GLYPH_H / 3, 2 * cdpc_pkg::GLYPH_W + 2, 0, 0, 0));
        queue_item(make_render((2 * cdpc_pkg::GLYPH_H) / 3, 4 * cdpc_pkg::GLYPH_W + 6,
                               0, 0, 0));
        queue_item(make_render(0, 2 * cdpc_pkg::GLYPH_W + 2, 0, 0, 0));
        queue_item(make_render(0, 0, 127, 0, 0));
        queue_item(make_render(0, 0, 100, 0, 0));
        queue_item(make_render(cdpc_pkg::GLYPH_H, 0, 0, 0, 0));
        queue_item(make_render(31, 127, 0, 0, 0));
        queue_item(make_render(0, cdpc_pkg::IMAGE_W, 0, 0, 0));
        queue_item(make_render(0, 127, 0, 0, 0));

        // Fill the whole store in shuffled order with some noise mixed in
        for (int i = 0; i < STORE_SIZE; i++)
            order.push_back(i);
        for (int i = STORE_SIZE - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        foreach (order[i]) begin
            queue_item(make_write(order[i] / (cdpc_pkg::GLYPH_H * cdpc_pkg::GLYPH_W),
                                  (order[i] / cdpc_pkg::GLYPH_W) % cdpc_pkg::GLYPH_H,
                                  order[i] % cdpc_pkg::GLYPH_W, $urandom_range(0, 15)));
            if ($urandom_range(0, 7) == 0)
                queue_item($urandom_range(0, 1) ? random_render() : random_write());
        end

        // Mostly renders over the filled store, with rewrites; hold twice for a drain
        it = random_render();
        it.hold_for_drain = 1'b1;
        queue_item(it);
        while (pending_items.size() < TOTAL_ITEMS) begin
            it = ($urandom_range(0, 3) == 0) ? random_write() : random_render();
            if (pending_items.size() == 1100)
                it.hold_for_drain = 1'b1;
            queue_item(it);
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive items at the falling edge, with random idle bursts and drain holds
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() == 0 ||
                         (pending_items[0].hold_for_drain && expected_pixels.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else if (may_idle() && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 9) - 1;
                s_tvalid <= 1'b0;
            end else begin
                cur_item = pending_items.pop_front();
                s_tdata  <= {7'b0, cur_item.ss, cur_item.mm, cur_item.hh, cur_item.level,
                             cur_item.col, cur_item.row, cur_item.digit};
                s_tuser  <= cur_item.kind;
                s_tvalid <= 1'b1;
            end
        end
    end

    // Stall the result side in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (may_idle() && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check results against the oldest expectation, then predict accepted items
    always @(posedge aclk) begin
        pixel_result_t want;
        taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected item, expected none, got pixel %0d in_range %0d",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata !== {4'b0, want.pixel} || m_tuser !== want.in_range) begin
                    $display("%0t: mismatch, expected pixel %0d in_range %0d, got pixel %0d in_range %0d",
                             $time, want.pixel, want.in_range, m_tdata, m_tuser);
                    mismatches++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            expected_pixels.push_back(predict_pixel(cur_item));
    end

endmodule

// ----- clock_digit_pixel_compositor.f -----
hdl/cdpc_pkg.sv
hdl/cdpc_glyph_ram.sv
hdl/cdpc_decode.sv
hdl/clock_digit_pixel_compositor.sv
hdl/cdpc_checker.sv
bench/clock_digit_pixel_compositor_tb.sv
